>>> rtl/core/lutf8_pkg.sv
// Shared types, constants and decode function for the lenient UTF-8 decoder.
package lutf8_pkg;

   // Depth of the queue between classifier and decoder
   localparam int QDepth = 2;
   localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW  = $clog2(QDepth + 1);

   // Byte classes produced by the front end
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ZERO  = 2'd0;
   localparam kind_type KIND_STRAY = 2'd1;
   localparam kind_type KIND_CONT  = 2'd2;
   localparam kind_type KIND_LEAD  = 2'd3;

   // Lead thresholds
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;

   // Classified byte as it travels through the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_val;
      logic [1:0] need;
   } item_type;

   // One decoded result
   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  bytes_used;
      logic        last;
   } res_type;

   // Assemble a code point from the lead and the gathered continuation payloads
   function automatic logic [20:0] decode(input logic [7:0] lead, input logic [1:0] n,
                                          input logic [17:0] bits);
      logic [20:0] cp;
      case (n)
         2'd3:    cp = {lead[2:0], bits[17:0]};
         2'd2:    cp = {5'd0, lead[3:0], bits[11:0]};
         2'd1:    cp = {10'd0, lead[4:0], bits[5:0]};
         default: cp = {13'd0, lead};
      endcase
      return cp;
   endfunction

endpackage

>>> rtl/core/lutf8_if.sv
// Request and response channel interfaces of the decoder.
interface lutf8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface lutf8_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  bytes_used;
   logic        last;

   modport source (output valid, output code_point, output bytes_used, output last,
                   input ready);
   modport sink (input valid, input code_point, input bytes_used, input last,
                 output ready);
endinterface

>>> rtl/core/lutf8_front.sv
// Front end: accepts request bytes and classifies them into a register stage.
module lutf8_front (
   input  logic               clock,
   input  logic               reset,
   lutf8_req_if.sink          req,
   output lutf8_pkg::item_type fr_item,
   output logic               fr_valid,
   input  logic               fr_ready
);

   logic                valid_ff, valid_in;
   lutf8_pkg::item_type item_ff, item_in;
   lutf8_pkg::item_type cls;
   logic                req_fire;

   // Classify the incoming byte
   always_comb begin
      cls.byte_val = req.in_byte;
      if (req.in_byte == 8'd0) begin
         cls.kind = lutf8_pkg::KIND_ZERO;
      end else if (req.in_byte[7:6] == 2'b10) begin
         cls.kind = lutf8_pkg::KIND_CONT;
      end else if (req.in_byte >= lutf8_pkg::LEAD_TWO) begin
         cls.kind = lutf8_pkg::KIND_LEAD;
      end else begin
         cls.kind = lutf8_pkg::KIND_STRAY;
      end
      if (req.in_byte >= lutf8_pkg::LEAD_FOUR) begin
         cls.need = 2'd3;
      end else if (req.in_byte >= lutf8_pkg::LEAD_THREE) begin
         cls.need = 2'd2;
      end else begin
         cls.need = 2'd1;
      end
   end

   assign req.ready = !valid_ff || fr_ready;
   assign req_fire  = req.valid && req.ready;

   // Hold the classified transaction until the queue takes it
   always_comb begin
      valid_in = valid_ff && !fr_ready;
      item_in  = item_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         item_in  = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign fr_valid = valid_ff;
   assign fr_item  = item_ff;

endmodule

>>> rtl/core/lutf8_queue.sv
// Short queue between the classifier and the decoder.
module lutf8_queue (
   input  logic                clock,
   input  logic                reset,
   input  lutf8_pkg::item_type wr_item,
   input  logic                wr_valid,
   output logic                wr_ready,
   output lutf8_pkg::item_type rd_item,
   output logic                rd_valid,
   input  logic                rd_ready
);

   lutf8_pkg::item_type                 mem_ff [lutf8_pkg::QDepth];
   logic [lutf8_pkg::QPtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [lutf8_pkg::QPtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [lutf8_pkg::QCntW-1:0]         count_ff, count_in;
   logic                                push, pop;

   assign wr_ready = count_ff != lutf8_pkg::QCntW'(lutf8_pkg::QDepth);
   assign rd_valid = count_ff != '0;
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lutf8_pkg::QPtrW'(lutf8_pkg::QDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lutf8_pkg::QPtrW'(lutf8_pkg::QDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed transactions
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> rtl/core/lutf8_back.sv
// Back end: sequence state, code point assembly and response registers.
module lutf8_back (
   input  logic                clock,
   input  logic                reset,
   input  lutf8_pkg::item_type q_item,
   input  logic                q_valid,
   output logic                q_ready,
   lutf8_rsp_if.source         rsp
);

   // Sequence state
   logic        pending_ff, pending_in;
   logic [7:0]  lead_ff, lead_in;
   logic [1:0]  need_ff, need_in;
   logic [1:0]  count_ff, count_in;
   logic [17:0] bits_ff, bits_in;

   // Response registers: output slot and a second slot for the raw byte after a flush
   logic                out_valid_ff, out_valid_in;
   lutf8_pkg::res_type  out_ff, out_in;
   logic                extra_valid_ff, extra_valid_in;
   lutf8_pkg::res_type  extra_ff, extra_in;

   lutf8_pkg::res_type  r0, r1;
   logic [1:0]          n_res;
   logic [1:0]          cnt_plus;
   logic [17:0]         shifted;
   logic                can_load, pop;

   assign can_load = !out_valid_ff || rsp.ready;
   assign pop      = can_load && !extra_valid_ff && q_valid;
   assign q_ready  = can_load && !extra_valid_ff;

   assign cnt_plus = count_ff + 2'd1;
   assign shifted  = {bits_ff[11:0], q_item.byte_val[5:0]};

   // Decode the head transaction against the open sequence
   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      need_in    = need_ff;
      count_in   = count_ff;
      bits_in    = bits_ff;
      r0         = '0;
      r1         = '0;
      n_res      = 2'd0;
      if (pending_ff && q_item.kind == lutf8_pkg::KIND_CONT) begin
         bits_in  = shifted;
         count_in = cnt_plus;
         if (cnt_plus >= need_ff) begin
            r0.code_point = lutf8_pkg::decode(lead_ff, cnt_plus, shifted);
            r0.bytes_used = {1'b0, cnt_plus} + 3'd1;
            r0.last       = 1'b1;
            n_res         = 2'd1;
            pending_in    = 1'b0;
            lead_in       = '0;
            count_in      = '0;
            bits_in       = '0;
         end
      end else begin
         // Flush the open sequence
         if (pending_ff) begin
            r0.code_point = lutf8_pkg::decode(lead_ff, count_ff, bits_ff);
            r0.bytes_used = {1'b0, count_ff} + 3'd1;
            n_res         = 2'd1;
            pending_in    = 1'b0;
            lead_in       = '0;
            count_in      = '0;
            bits_in       = '0;
         end
         if (q_item.kind == lutf8_pkg::KIND_LEAD) begin
            pending_in = 1'b1;
            lead_in    = q_item.byte_val;
            need_in    = q_item.need;
            count_in   = '0;
            bits_in    = '0;
         end else if (q_item.kind != lutf8_pkg::KIND_ZERO) begin
            // Pass a stray byte through unchanged
            if (pending_ff) begin
               r1.code_point = {13'd0, q_item.byte_val};
               r1.bytes_used = 3'd1;
               n_res         = 2'd2;
            end else begin
               r0.code_point = {13'd0, q_item.byte_val};
               r0.bytes_used = 3'd1;
               n_res         = 2'd1;
            end
         end
         r0.last = (n_res == 2'd1);
         r1.last = (n_res == 2'd2);
      end
   end

   // Load the output slot from the second slot first, else from the popped transaction
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_in         = out_ff;
      extra_valid_in = extra_valid_ff;
      extra_in       = extra_ff;
      if (can_load && extra_valid_ff) begin
         out_valid_in   = 1'b1;
         out_in         = extra_ff;
         extra_valid_in = 1'b0;
      end else if (pop) begin
         out_valid_in = n_res != 2'd0;
         out_in       = r0;
         if (n_res == 2'd2) begin
            extra_valid_in = 1'b1;
            extra_in       = r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= 1'b0;
         lead_ff        <= '0;
         need_ff        <= 2'd1;
         count_ff       <= '0;
         bits_ff        <= '0;
         out_valid_ff   <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pending_ff <= pending_in;
            lead_ff    <= lead_in;
            need_ff    <= need_in;
            count_ff   <= count_in;
            bits_ff    <= bits_in;
         end
         out_valid_ff   <= out_valid_in;
         extra_valid_ff <= extra_valid_in;
      end
      out_ff   <= out_in;
      extra_ff <= extra_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.code_point = out_ff.code_point;
   assign rsp.bytes_used = out_ff.bytes_used;
   assign rsp.last       = out_ff.last;

   // Second slot only fills behind an occupied output slot
   a_extra_behind_out: assert property (@(posedge clock) disable iff (reset)
      extra_valid_ff |-> out_valid_ff)
      else $error("second result slot valid with empty output slot");

   // The flushed sequence ahead of a raw byte never closes the transaction
   a_extra_not_last: assert property (@(posedge clock) disable iff (reset)
      extra_valid_ff |-> !out_ff.last)
      else $error("flushed result marked last while raw byte waits");

   // An open sequence never holds all the continuations it wants
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (count_ff < need_ff))
      else $error("open sequence holds a complete set of continuations");

   // A two-result transaction parks its raw byte in the second slot
   a_two_results: assert property (@(posedge clock) disable iff (reset)
      (pop && n_res == 2'd2) |=> extra_valid_ff)
      else $error("second result of a transaction lost");

endmodule

>>> rtl/core/lenient_utf8_decoder_core.sv
// Top level of the lenient UTF-8 decoder: classifier, queue and decoder.
// Path: classifier register, then the queue, then the decoder's output register.
// Throughput: one byte per cycle while the response is taken; a byte that flushes a
// sequence and also passes through raw holds the decoder while its raw byte sits in the
// second slot: a one-cycle input stall unless an idle cycle of the stream absorbs it.
// Reset: synchronous, active high; clears the open sequence, the queue and all valids.
module lenient_utf8_decoder_core (
   input  logic        clock,
   input  logic        reset,
   lutf8_req_if.sink   req,
   lutf8_rsp_if.source rsp
);

   lutf8_pkg::item_type fr_item, q_item;
   logic                fr_valid, fr_ready;
   logic                q_valid, q_ready;

   // Accept and classify bytes
   lutf8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .fr_item  (fr_item),
      .fr_valid (fr_valid),
      .fr_ready (fr_ready)
   );

   // Decouple classifier from decoder
   lutf8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_item  (fr_item),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .rd_item  (q_item),
      .rd_valid (q_valid),
      .rd_ready (q_ready)
   );

   // Track sequences and emit code points
   lutf8_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

endmodule

>>> tb/sv/lenient_utf8_decoder_core_test.sv
// Self-checking testbench for the lenient UTF-8 decoder core: directed table plus random streams.
`timescale 1ns / 1ps

module lenient_utf8_decoder_core_test;

   // One byte offered on the request channel, with its typed expectation if any
   typedef struct {
      logic [7:0]         b;
      bit                 typed;
      int                 n;
      lutf8_pkg::res_type r;
   } offer_type;

   localparam int TotalBytes = 1650;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lutf8_req_if req_ch ();
   lutf8_rsp_if rsp_ch ();

   lenient_utf8_decoder_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Decoder state mirrored by the predictor
   logic        seq_open    = 1'b0;
   logic [7:0]  seq_lead    = 8'd0;
   logic [1:0]  seq_conts   = 2'd0;
   logic [17:0] seq_payload = 18'd0;

   offer_type          directed_rows[$];
   offer_type          bytes_offered[$];
   lutf8_pkg::res_type cp_expected[$];

   bit src_calm  = 1'b0;
   bit snk_calm  = 1'b0;
   int fail_count      = 0;
   int bytes_accepted  = 0;
   int results_checked = 0;
   int early_flushes   = 0;
   int double_results  = 0;
   int zero_bytes      = 0;
   int nonzero_sent    = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic lutf8_pkg::res_type make_res(input logic [20:0] cp,
                                                   input logic [2:0] used);
      lutf8_pkg::res_type r;
      r.code_point = cp;
      r.bytes_used = used;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic lutf8_pkg::kind_type classify(input logic [7:0] b);
      if (b == 8'd0) return lutf8_pkg::KIND_ZERO;
      if (b >= lutf8_pkg::LEAD_TWO) return lutf8_pkg::KIND_LEAD;
      if (b[7:6] == 2'b10) return lutf8_pkg::KIND_CONT;
      return lutf8_pkg::KIND_STRAY;
   endfunction

   function automatic logic [1:0] conts_wanted(input logic [7:0] lead);
      if (lead >= lutf8_pkg::LEAD_FOUR) return 2'd3;
      if (lead >= lutf8_pkg::LEAD_THREE) return 2'd2;
      return 2'd1;
   endfunction

   // Code point of the open sequence, masked by how many continuations arrived
   function automatic logic [20:0] flushed_point();
      logic [20:0] lead_w;
      lead_w = {13'd0, seq_lead};
      case (seq_conts)
         2'd3:    return ((lead_w & 21'h07) << 18) | {3'd0, seq_payload};
         2'd2:    return ((lead_w & 21'h0F) << 12) | {9'd0, seq_payload[11:0]};
         2'd1:    return ((lead_w & 21'h1F) << 6) | {15'd0, seq_payload[5:0]};
         default: return lead_w;
      endcase
   endfunction

   function automatic lutf8_pkg::res_type close_sequence();
      lutf8_pkg::res_type r;
      r = make_res(flushed_point(), {1'b0, seq_conts} + 3'd1);
      seq_open    = 1'b0;
      seq_lead    = 8'd0;
      seq_conts   = 2'd0;
      seq_payload = 18'd0;
      return r;
   endfunction

   // Advance the mirrored decoder by one byte and return the code points it yields
   function automatic void decode_step(input logic [7:0] b, output int n,
                                       output lutf8_pkg::res_type r0,
                                       output lutf8_pkg::res_type r1);
      lutf8_pkg::kind_type k;
      lutf8_pkg::res_type  raw;
      k   = classify(b);
      n   = 0;
      r0  = '0;
      r1  = '0;
      raw = make_res({13'd0, b}, 3'd1);
      if (seq_open && k == lutf8_pkg::KIND_CONT) begin
         seq_payload = {seq_payload[11:0], b[5:0]};
         seq_conts   = seq_conts + 2'd1;
         if (seq_conts >= conts_wanted(seq_lead)) begin
            r0      = close_sequence();
            r0.last = 1'b1;
            n       = 1;
         end
         return;
      end
      // Anything else ends an open sequence early
      if (seq_open) begin
         r0 = close_sequence();
         n  = 1;
         early_flushes++;
      end
      case (k)
         lutf8_pkg::KIND_LEAD: begin
            seq_open = 1'b1;
            seq_lead = b;
         end
         lutf8_pkg::KIND_ZERO: ;
         default: begin
            if (n == 0) r0 = raw;
            else r1 = raw;
            n++;
         end
      endcase
      if (n == 1) r0.last = 1'b1;
      else if (n == 2) r1.last = 1'b1;
   endfunction

   function automatic int idle_len(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(12, 30);
   endfunction

   function automatic void add_row(input logic [7:0] b, input bit typed, input int n,
                                   input logic [20:0] cp, input logic [2:0] used);
      offer_type d;
      d.b      = b;
      d.typed  = typed;
      d.n      = n;
      d.r      = make_res(cp, used);
      d.r.last = 1'b1;
      directed_rows.push_back(d);
   endfunction

   // Offer one byte after a random gap and hold it until the transaction completes
   task automatic offer_byte(input offer_type d);
      int gap;
      if ($urandom_range(0, 79) == 0) src_calm = !src_calm;
      gap = idle_len(src_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      bytes_offered.push_back(d);
      if (d.b == 8'd0) zero_bytes++;
      else nonzero_sent++;
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= d.b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      offer_type d;
      d.b     = b;
      d.typed = 1'b0;
      d.n     = 0;
      d.r     = '0;
      offer_byte(d);
   endtask

   // Predict on every accepted byte, then check every accepted result
   always @(posedge clock) begin
      offer_type          d;
      int                 n;
      lutf8_pkg::res_type r0, r1, want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            d = bytes_offered.pop_front();
            decode_step(d.b, n, r0, r1);
            bytes_accepted++;
            if (n == 2) double_results++;
            if (d.typed) begin
               if (d.n > 0) cp_expected.push_back(d.r);
            end else begin
               if (n > 0) cp_expected.push_back(r0);
               if (n > 1) cp_expected.push_back(r1);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (cp_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, got cp %h used %0d last %0d",
                        $time, rsp_ch.code_point, rsp_ch.bytes_used, rsp_ch.last);
               fail_count++;
            end else begin
               want = cp_expected.pop_front();
               if (rsp_ch.code_point !== want.code_point) begin
                  $display("%0t: code_point expected %h, got %h",
                           $time, want.code_point, rsp_ch.code_point);
                  fail_count++;
               end
               if (rsp_ch.bytes_used !== want.bytes_used) begin
                  $display("%0t: bytes_used expected %0d, got %0d",
                           $time, want.bytes_used, rsp_ch.bytes_used);
                  fail_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t: last expected %0d, got %0d", $time, want.last, rsp_ch.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Response side: ready in bursts with random stalls, sometimes a calm stretch
   initial begin
      int run;
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
         run   = snk_calm ? $urandom_range(20, 60) : $urandom_range(1, 6);
         stall = idle_len(snk_calm);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Hard stop in case the decoder hangs
   initial begin
      #10_000_000;
      $display("lenient_utf8_decoder_core verification failed");
      $finish;
   end

   initial begin
      int         pick;
      int         len;
      int         k;
      logic [7:0] lead;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'd0;

      // Directed table: raw bytes and extremes typed in, sequences predicted
      add_row(8'h00, 1'b1, 0, 21'h0, 3'd0);        // terminator with nothing open
      add_row(8'h41, 1'b1, 1, 21'h41, 3'd1);
      add_row(8'h80, 1'b1, 1, 21'h80, 3'd1);       // stray continuation
      add_row(8'hC3, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'hA9, 1'b0, 0, 21'h0, 3'd0);
      add_row(8'hE2, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h82, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'hAC, 1'b0, 0, 21'h0, 3'd0);
      add_row(8'hFF, 1'b1, 0, 21'h0, 3'd0);        // top lead acts like a four-byte lead
      add_row(8'hBF, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'hBF, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'hBF, 1'b1, 1, 21'h1FFFFF, 3'd4);
      add_row(8'hF0, 1'b1, 0, 21'h0, 3'd0);        // overlong zero passes unchecked
      add_row(8'h80, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h80, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h80, 1'b1, 1, 21'h0, 3'd4);
      add_row(8'hE0, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h80, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h41, 1'b0, 0, 21'h0, 3'd0);        // flush plus raw byte
      add_row(8'hC5, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'hC0, 1'b1, 1, 21'hC5, 3'd1);       // lead interrupting a lead
      add_row(8'h00, 1'b1, 1, 21'hC0, 3'd1);       // terminator flushing a bare lead
      add_row(8'hF8, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h90, 1'b1, 0, 21'h0, 3'd0);
      add_row(8'h00, 1'b0, 0, 21'h0, 3'd0);        // terminator flushing a short sequence

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer_byte(directed_rows[i]);

      // Random part: well-formed sequences half the time, else broken ones, terminators and noise
      while (nonzero_sent + zero_bytes < TotalBytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            len = $urandom_range(1, 4);
            case (len)
               1:       send_byte(8'($urandom_range(1, 127)));
               2:       send_byte(8'($urandom_range(8'hC0, 8'hDF)));
               3:       send_byte(8'($urandom_range(8'hE0, 8'hEF)));
               default: send_byte(8'($urandom_range(8'hF0, 8'hFF)));
            endcase
            for (k = 1; k < len; k++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
         end else if (pick < 65) begin
            lead = 8'($urandom_range(8'hC0, 8'hFF));
            len  = $urandom_range(0, conts_wanted(lead) - 1);
            send_byte(lead);
            for (k = 0; k < len; k++) send_byte(8'h80 | 8'($urandom_range(0, 63)));
         end else if (pick < 73) begin
            send_byte(8'h00);
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end

      // Drain: let the last transaction reach the predictor, wait out every
      // expected result, then the pipeline latency
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (cp_expected.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d bytes (%0d directed, %0d terminators), %0d results checked",
               bytes_accepted, directed_rows.size(), zero_bytes, results_checked);
      $display("sequences cut short %0d, bytes giving two results %0d",
               early_flushes, double_results);
      if (fail_count == 0) begin
         $display("lenient_utf8_decoder_core verification clean");
      end else begin
         $display("lenient_utf8_decoder_core verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lutf8_pkg.sv
rtl/core/lutf8_if.sv
rtl/core/lutf8_front.sv
rtl/core/lutf8_queue.sv
rtl/core/lutf8_back.sv
rtl/core/lenient_utf8_decoder_core.sv
tb/sv/lenient_utf8_decoder_core_test.sv
